>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Widths, controller states and control/status bundles of the DDA rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    // signed position: sign + integer + fraction
    localparam int POS_W      = COORD_BITS + FRAC_BITS + 1;
    // step magnitude: one integer bit + fraction
    localparam int Q_W        = FRAC_BITS + 1;
    // points still to emit
    localparam int PL_W       = COORD_BITS + 1;
    // divider iteration counter, holds FRAC_BITS down to 0
    localparam int CNT_W      = $clog2(FRAC_BITS + 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_DIV
    } state_t;

    typedef struct packed {
        logic start;     // load a new line, emit its first point
        logic advance;   // step the line, emit the next point
        logic div_step;  // run one divider iteration
    } cmd_t;

    typedef struct packed {
        logic len_zero;  // endpoints at the input are equal
        logic div_last;  // divider is on its final iteration
        logic out_full;  // output register holds an untaken result
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/dda_ctrl.sv
// ----------------------------------------------------------------------------
// dda_ctrl
// Controller: input handshake and sequencing of the step divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             action,
    input  wire logic             out_ready,
    input  wire dda_pkg::status_t status,
    output dda_pkg::cmd_t         cmd
);

    dda_pkg::state_t state_reg;
    dda_pkg::state_t state_next;
    logic            accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dda_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.start    = 1'b0;
        cmd.advance  = 1'b0;
        cmd.div_step = 1'b0;
        accept       = 1'b0;
        case (state_reg)
            dda_pkg::S_IDLE:
            begin
                // take a request when the output slot is empty or frees this cycle
                in_ready    = !status.out_full || out_ready;
                accept      = in_valid && in_ready;
                cmd.start   = accept && !action;
                cmd.advance = accept && action;
                if (cmd.start && !status.len_zero)
                begin
                    state_next = dda_pkg::S_DIV;
                end
            end
            dda_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = dda_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dda_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/dda_dp.sv
// ----------------------------------------------------------------------------
// dda_dp
// Datapath: positions, radix-2 step divider, point counter, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dda_pkg::cmd_t                  cmd,
    output dda_pkg::status_t                    status,
    input  wire logic [dda_pkg::COORD_BITS-1:0] start_x,
    input  wire logic [dda_pkg::COORD_BITS-1:0] start_y,
    input  wire logic [dda_pkg::COORD_BITS-1:0] end_x,
    input  wire logic [dda_pkg::COORD_BITS-1:0] end_y,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [dda_pkg::COORD_BITS-1:0]      pixel_x,
    output logic [dda_pkg::COORD_BITS-1:0]      pixel_y,
    output logic                                point_valid,
    output logic                                last_point
);

    localparam int CB = dda_pkg::COORD_BITS;
    localparam int FB = dda_pkg::FRAC_BITS;
    localparam int PW = dda_pkg::POS_W;
    localparam int QW = dda_pkg::Q_W;

    // line state
    logic [PW-1:0]                pos_x_reg, pos_y_reg;
    logic [QW-1:0]                q_x_reg, q_y_reg;
    logic                         neg_x_reg, neg_y_reg;
    logic [dda_pkg::PL_W-1:0]     points_left_reg;
    logic                         line_active_reg;
    // divider
    logic [CB:0]                  rem_x_reg, rem_y_reg;
    logic [CB-1:0]                len_reg;
    logic [dda_pkg::CNT_W-1:0]    cnt_reg;
    // output slot
    logic                         out_full_reg;
    logic [CB-1:0]                px_reg, py_reg;
    logic                         pv_reg, lp_reg;

    logic                         x_neg, y_neg;
    logic [CB-1:0]                adx, ady, len;
    logic [PW-1:0]                pos_x_next, pos_y_next;
    logic                         ge_x, ge_y;
    logic [CB:0]                  sub_x, sub_y;
    logic                         is_last;
    logic                         load_out;

    // setup: magnitudes and step count of the new line
    always_comb
    begin
        x_neg = end_x < start_x;
        y_neg = end_y < start_y;
        adx   = x_neg ? (start_x - end_x) : (end_x - start_x);
        ady   = y_neg ? (start_y - end_y) : (end_y - start_y);
        len   = (adx >= ady) ? adx : ady;
    end

    // one divider iteration per lane
    always_comb
    begin
        ge_x  = rem_x_reg >= {1'b0, len_reg};
        ge_y  = rem_y_reg >= {1'b0, len_reg};
        sub_x = ge_x ? (rem_x_reg - {1'b0, len_reg}) : rem_x_reg;
        sub_y = ge_y ? (rem_y_reg - {1'b0, len_reg}) : rem_y_reg;
    end

    // advance: add or subtract the step magnitude
    always_comb
    begin
        pos_x_next = neg_x_reg ? (pos_x_reg - {{(PW-QW){1'b0}}, q_x_reg})
                               : (pos_x_reg + {{(PW-QW){1'b0}}, q_x_reg});
        pos_y_next = neg_y_reg ? (pos_y_reg - {{(PW-QW){1'b0}}, q_y_reg})
                               : (pos_y_reg + {{(PW-QW){1'b0}}, q_y_reg});
        is_last    = points_left_reg == {{(dda_pkg::PL_W-1){1'b0}}, 1'b1};
    end

    assign load_out = cmd.start || cmd.advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            q_x_reg         <= '0;
            q_y_reg         <= '0;
            neg_x_reg       <= 1'b0;
            neg_y_reg       <= 1'b0;
            points_left_reg <= '0;
            line_active_reg <= 1'b0;
            rem_x_reg       <= '0;
            rem_y_reg       <= '0;
            len_reg         <= '0;
            cnt_reg         <= '0;
            out_full_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                // start position plus one half where the coordinate is not zero
                pos_x_reg       <= {1'b0, start_x, (start_x != '0), {(FB-1){1'b0}}};
                pos_y_reg       <= {1'b0, start_y, (start_y != '0), {(FB-1){1'b0}}};
                neg_x_reg       <= x_neg;
                neg_y_reg       <= y_neg;
                q_x_reg         <= '0;
                q_y_reg         <= '0;
                rem_x_reg       <= {1'b0, adx};
                rem_y_reg       <= {1'b0, ady};
                len_reg         <= len;
                cnt_reg         <= dda_pkg::CNT_W'(FB);
                points_left_reg <= {1'b0, len};
                line_active_reg <= len != '0;
            end
            else if (cmd.advance && line_active_reg)
            begin
                pos_x_reg       <= pos_x_next;
                pos_y_reg       <= pos_y_next;
                points_left_reg <= points_left_reg - dda_pkg::PL_W'(1);
                line_active_reg <= !is_last;
            end

            if (cmd.div_step)
            begin
                q_x_reg   <= {q_x_reg[QW-2:0], ge_x};
                q_y_reg   <= {q_y_reg[QW-2:0], ge_y};
                rem_x_reg <= {sub_x[CB-1:0], 1'b0};
                rem_y_reg <= {sub_y[CB-1:0], 1'b0};
                cnt_reg   <= cnt_reg - dda_pkg::CNT_W'(1);
            end

            if (load_out)
            begin
                out_full_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            px_reg <= start_x;
            py_reg <= start_y;
            pv_reg <= 1'b1;
            lp_reg <= len == '0;
        end
        else if (cmd.advance)
        begin
            if (line_active_reg)
            begin
                px_reg <= pos_x_next[FB +: CB];
                py_reg <= pos_y_next[FB +: CB];
                pv_reg <= 1'b1;
                lp_reg <= is_last;
            end
            else
            begin
                px_reg <= '0;
                py_reg <= '0;
                pv_reg <= 1'b0;
                lp_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.len_zero = len == '0;
        status.div_last = cnt_reg == '0;
        status.out_full = out_full_reg;
    end

    assign out_valid   = out_full_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign point_valid = pv_reg;
    assign last_point  = lp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dda_line_rasterizer_unit.sv
// A result is registered and shows in the cycle after its request is accepted.
// Throughput: next-point requests go one per cycle while the result side takes each point (one accumulate per point).
// A start with distinct endpoints blocks input while the restoring divider finds both
// step increments one quotient bit per cycle.
// Reset: asynchronous, active low; the block comes up idle with no line active and
// the output slot empty.
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// DDA line rasterizer: one point per next request, endpoints included.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dda_line_rasterizer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [dda_pkg::COORD_BITS-1:0] start_x,
    input  wire logic [dda_pkg::COORD_BITS-1:0] start_y,
    input  wire logic [dda_pkg::COORD_BITS-1:0] end_x,
    input  wire logic [dda_pkg::COORD_BITS-1:0] end_y,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [dda_pkg::COORD_BITS-1:0]      pixel_x,
    output logic [dda_pkg::COORD_BITS-1:0]      pixel_y,
    output logic                                point_valid,
    output logic                                last_point
);

    dda_pkg::cmd_t    cmd;
    dda_pkg::status_t status;

    // Controller: hold input off while the divider runs, and while the
    // output slot is full and not being drained.
    dda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: the first point of a line is the start coordinate itself, so
    // it is emitted at once; the increments are ready before the next request
    // can be taken. Each next request adds the signed step and truncates.
    dda_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .point_valid (point_valid),
        .last_point  (last_point)
    );

    // a request is taken only when its result has a free slot
    `ASSERT_IMPLY(a_no_overrun, clk, rst_n, in_valid && in_ready, !out_valid || out_ready)
    // a start with distinct endpoints holds input off for the division
    `ASSERT_NEXT(a_div_blocks, clk, rst_n,
                 in_valid && in_ready && !action && ((start_x != end_x) || (start_y != end_y)),
                 !in_ready)
    // the last-point flag only rides on an emitted point
    `ASSERT_IMPLY(a_last_has_point, clk, rst_n, out_valid && last_point, point_valid)

endmodule

`default_nettype wire

>>> test/dda_line_rasterizer_unit_tb.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer testbench
// Feeds start and next-point requests through the valid/ready request channel,
// predicts every point in a cycle-free DDA model kept here, and checks each
// point taken from the result channel against the oldest prediction. Both
// channels idle at random; one phase starves the result side so the block
// backs up, another runs with no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_line_rasterizer_unit_tb;

    // Request codes carried on the action field
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    localparam int  COORD_MAX      = (1 << dda_pkg::COORD_BITS) - 1;
    localparam int  WATCHDOG_LIMIT = 3000;
    // output register plus the divider run of a start request
    localparam int  DRAIN_CYCLES   = dda_pkg::FRAC_BITS + 8;
    localparam int  STALL_CYCLES   = 300;
    localparam logic signed [dda_pkg::POS_W-1:0] HALF_FIXED =
        dda_pkg::POS_W'(1 << (dda_pkg::FRAC_BITS - 1));

    typedef struct packed {
        logic                           action;
        logic [dda_pkg::COORD_BITS-1:0] start_x;
        logic [dda_pkg::COORD_BITS-1:0] start_y;
        logic [dda_pkg::COORD_BITS-1:0] end_x;
        logic [dda_pkg::COORD_BITS-1:0] end_y;
    } line_req_t;

    typedef struct packed {
        logic [dda_pkg::COORD_BITS-1:0] pixel_x;
        logic [dda_pkg::COORD_BITS-1:0] pixel_y;
        logic                           point_valid;
        logic                           last_point;
    } point_t;

    // ------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    logic                           action      = ACT_START;
    logic [dda_pkg::COORD_BITS-1:0] start_x     = '0;
    logic [dda_pkg::COORD_BITS-1:0] start_y     = '0;
    logic [dda_pkg::COORD_BITS-1:0] end_x       = '0;
    logic [dda_pkg::COORD_BITS-1:0] end_y       = '0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    logic [dda_pkg::COORD_BITS-1:0] pixel_x;
    logic [dda_pkg::COORD_BITS-1:0] pixel_y;
    logic                           point_valid;
    logic                           last_point;

    dda_line_rasterizer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .point_valid (point_valid),
        .last_point  (last_point)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    line_req_t pending_requests[$];   // requests waiting for the driver
    point_t    expected_points[$];    // predicted points, oldest first
    int        send_gap_max   = 16;
    int        recv_gap_max   = 16;
    int        hold_cycles    = 0;    // one-shot long stall for the receiver
    int        mismatch_count = 0;
    bit        driver_busy    = 1'b0; // a popped request is not yet accepted

    // ------------------------------------------------------------------
    // Line walker: mirrors the rasterizer state at the block's widths
    // ------------------------------------------------------------------
    logic signed [dda_pkg::POS_W-1:0] walk_pos_x  = '0;
    logic signed [dda_pkg::POS_W-1:0] walk_pos_y  = '0;
    logic signed [dda_pkg::Q_W:0]     walk_step_x = '0;
    logic signed [dda_pkg::Q_W:0]     walk_step_y = '0;
    logic [dda_pkg::PL_W-1:0]         walk_left   = '0;
    logic                             walk_active = 1'b0;

    // Per-step increment: magnitude divided, truncated, sign applied last.
    function automatic logic signed [dda_pkg::Q_W:0] step_increment(input int d,
                                                                    input int len);
        logic [dda_pkg::COORD_BITS+dda_pkg::FRAC_BITS-1:0] num;
        logic [dda_pkg::COORD_BITS+dda_pkg::FRAC_BITS-1:0] quo;
        num = (dda_pkg::COORD_BITS+dda_pkg::FRAC_BITS)'((d < 0) ? -d : d);
        num = num << dda_pkg::FRAC_BITS;
        quo = (dda_pkg::COORD_BITS+dda_pkg::FRAC_BITS)'(num / len);
        if (d < 0)
            return -$signed({1'b0, quo[dda_pkg::Q_W-1:0]});
        return $signed({1'b0, quo[dda_pkg::Q_W-1:0]});
    endfunction

    // Start position: coordinate in fixed point, plus one half unless zero.
    function automatic logic signed [dda_pkg::POS_W-1:0] start_position(
        input logic [dda_pkg::COORD_BITS-1:0] c);
        logic signed [dda_pkg::POS_W-1:0] p;
        p = {1'b0, c, {dda_pkg::FRAC_BITS{1'b0}}};
        if (c != '0)
            p = p + HALF_FIXED;
        return p;
    endfunction

    function automatic logic [dda_pkg::COORD_BITS-1:0] pixel_of(
        input logic signed [dda_pkg::POS_W-1:0] p);
        if (p < 0)
            return '0;
        return p[dda_pkg::FRAC_BITS +: dda_pkg::COORD_BITS];
    endfunction

    // Advance the walker by one accepted request and return the point it yields.
    function automatic point_t trace_point(input line_req_t req);
        point_t pt;
        int     dx;
        int     dy;
        int     len;
        pt = '0;
        if (req.action == ACT_START)
        begin
            dx  = int'(req.end_x) - int'(req.start_x);
            dy  = int'(req.end_y) - int'(req.start_y);
            len = ((dx < 0) ? -dx : dx) >= ((dy < 0) ? -dy : dy) ?
                  ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
            walk_pos_x = start_position(req.start_x);
            walk_pos_y = start_position(req.start_y);
            if (len == 0)
            begin
                walk_step_x = '0;
                walk_step_y = '0;
                walk_left   = '0;
                walk_active = 1'b0;
            end
            else
            begin
                walk_step_x = step_increment(dx, len);
                walk_step_y = step_increment(dy, len);
                walk_left   = dda_pkg::PL_W'(len);
                walk_active = 1'b1;
            end
            pt.pixel_x     = pixel_of(walk_pos_x);
            pt.pixel_y     = pixel_of(walk_pos_y);
            pt.point_valid = 1'b1;
            pt.last_point  = (len == 0);
        end
        else if (walk_active)
        begin
            walk_pos_x = walk_pos_x + walk_step_x;
            walk_pos_y = walk_pos_y + walk_step_y;
            walk_left  = walk_left - dda_pkg::PL_W'(1);
            if (walk_left == '0)
                walk_active = 1'b0;
            pt.pixel_x     = pixel_of(walk_pos_x);
            pt.pixel_y     = pixel_of(walk_pos_y);
            pt.point_valid = 1'b1;
            pt.last_point  = (walk_left == '0);
        end
        // a next request with no line active yields an all-zero point
        return pt;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pop queued requests, draw a gap for each, hold valid
    // and payload until the handshake, then predict the point.
    // ------------------------------------------------------------------
    initial
    begin : request_driver
        line_req_t req;
        int        gap;
        @(posedge rst_n);
        @(posedge clk);
        gap = $urandom_range(0, send_gap_max);
        forever
        begin
            while (pending_requests.size() == 0)
                @(posedge clk);
            repeat (gap) @(posedge clk);
            req         = pending_requests.pop_front();
            driver_busy = 1'b1;
            in_valid <= 1'b1;
            action   <= req.action;
            start_x  <= req.start_x;
            start_y  <= req.start_y;
            end_x    <= req.end_x;
            end_y    <= req.end_y;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            expected_points.push_back(trace_point(req));
            driver_busy = 1'b0;
            // keep valid high only when the next request goes out back to back;
            // otherwise drop it and wait on the clock so it is never lowered
            // and raised in the same step
            gap = $urandom_range(0, send_gap_max);
            if (pending_requests.size() == 0 || gap > 0)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: draw a wait per point, or take a one-shot long hold
    // ------------------------------------------------------------------
    initial
    begin : result_receiver
        int wait_cycles;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                wait_cycles = hold_cycles;
                hold_cycles = 0;
            end
            else
                wait_cycles = $urandom_range(0, recv_gap_max);
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Point checker: compare each taken point with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : point_checker
        point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
                report_mismatch("point with nothing pending", {pixel_x, pixel_y}, 0);
            else
            begin
                want = expected_points.pop_front();
                if (pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", pixel_x, want.pixel_x);
                if (pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", pixel_y, want.pixel_y);
                if (point_valid !== want.point_valid)
                    report_mismatch("point_valid", point_valid, want.point_valid);
                if (last_point !== want.last_point)
                    report_mismatch("last_point", last_point, want.last_point);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles with work outstanding and no handshake
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        int stall_count;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_count = 0;
        else if (in_valid || expected_points.size() != 0)
        begin
            stall_count++;
            if (stall_count >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request builders and helpers
    // ------------------------------------------------------------------
    task automatic queue_start(input int sx, input int sy, input int ex, input int ey);
        line_req_t req;
        req.action  = ACT_START;
        req.start_x = dda_pkg::COORD_BITS'(sx);
        req.start_y = dda_pkg::COORD_BITS'(sy);
        req.end_x   = dda_pkg::COORD_BITS'(ex);
        req.end_y   = dda_pkg::COORD_BITS'(ey);
        pending_requests.push_back(req);
    endtask

    // Next request; coordinates are noise that the block must ignore.
    task automatic queue_next();
        line_req_t req;
        req.action  = ACT_NEXT;
        req.start_x = dda_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        req.start_y = dda_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        req.end_x   = dda_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        req.end_y   = dda_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        pending_requests.push_back(req);
    endtask

    // Hold until every queued request is accepted and every point has come.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || driver_busy || expected_points.size() != 0)
            @(posedge clk);
    endtask

    function automatic int clamp_coord(input int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Next requests straight out of reset: no line, all-zero points.
    task automatic test_idle_next();
        queue_next();
        queue_next();
        wait_drained();
    endtask

    // Equal endpoints at both corners and mid-range: one point, flagged last.
    task automatic test_zero_length();
        queue_start(0, 0, 0, 0);
        queue_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_start(512, 7, 512, 7);
        queue_next();
        wait_drained();
    endtask

    // Short steep line going left, walked to its end plus one idle next.
    task automatic test_short_line();
        queue_start(5, 3, 2, 7);
        repeat (5) queue_next();
        wait_drained();
    endtask

    // Restart while a line is still active, with corner endpoints.
    task automatic test_restart_mid_line();
        queue_start(0, 0, COORD_MAX, COORD_MAX);
        repeat (3) queue_next();
        queue_start(COORD_MAX, 0, 0, COORD_MAX);
        repeat (2) queue_next();
        queue_start(COORD_MAX, COORD_MAX, 0, 0);
        queue_start(0, COORD_MAX, COORD_MAX, 0);
        queue_next();
        wait_drained();
    endtask

    // Long line walked end to end with no idling on either side.
    task automatic test_long_line();
        send_gap_max = 0;
        recv_gap_max = 0;
        queue_start(COORD_MAX, 0, COORD_MAX - 150, 100);
        repeat (152) queue_next();
        wait_drained();
        send_gap_max = 16;
        recv_gap_max = 16;
    endtask

    // Starve the result side while requests keep coming back to back.
    task automatic test_output_stall();
        send_gap_max = 0;
        hold_cycles  = STALL_CYCLES;
        queue_start(100, 900, 140, 870);
        repeat (40) queue_next();
        wait_drained();
        send_gap_max = 16;
    endtask

    // Pause mid-line until every point is back, then resume the walk.
    task automatic test_drain_pause();
        queue_start(300, 20, 310, 45);
        repeat (10) queue_next();
        wait_drained();
        repeat (17) queue_next();
        wait_drained();
    endtask

    // Mostly well-formed short lines walked to the end; the rest are wide
    // lines abandoned early, lines cut short, zero-length lines and stray nexts.
    task automatic test_random_lines(input int n_items);
        int queued;
        int pick;
        int sx;
        int sy;
        int ex;
        int ey;
        int len;
        int walk;
        queued = 0;
        while (queued < n_items)
        begin
            pick = $urandom_range(0, 99);
            sx   = $urandom_range(0, COORD_MAX);
            sy   = $urandom_range(0, COORD_MAX);
            if (pick >= 94)
            begin
                queue_next();
                queued++;
            end
            else
            begin
                if (pick < 70)
                begin
                    ex = clamp_coord(sx + int'($urandom_range(0, 24)) - 12);
                    ey = clamp_coord(sy + int'($urandom_range(0, 24)) - 12);
                end
                else if (pick < 76)
                begin
                    // corner endpoints
                    sx = $urandom_range(0, 1) ? COORD_MAX : 0;
                    sy = $urandom_range(0, 1) ? COORD_MAX : 0;
                    ex = $urandom_range(0, 1) ? COORD_MAX : 0;
                    ey = $urandom_range(0, 1) ? COORD_MAX : 0;
                end
                else if (pick < 87)
                begin
                    ex = $urandom_range(0, COORD_MAX);
                    ey = $urandom_range(0, COORD_MAX);
                end
                else
                begin
                    ex = sx;
                    ey = sy;
                end
                len = ((ex > sx) ? ex - sx : sx - ex) >= ((ey > sy) ? ey - sy : sy - ey) ?
                      ((ex > sx) ? ex - sx : sx - ex) : ((ey > sy) ? ey - sy : sy - ey);
                if (pick < 10)
                    walk = $urandom_range(0, len);
                else if (pick < 70)
                    walk = len + $urandom_range(0, 1);
                else if (pick < 87)
                    walk = $urandom_range(0, 16);
                else
                    walk = $urandom_range(0, 1);
                queue_start(sx, sy, ex, ey);
                repeat (walk) queue_next();
                queued += walk + 1;
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, run each test, drain, report
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_next();
        test_zero_length();
        test_short_line();
        test_restart_mid_line();
        test_long_line();
        test_output_stall();
        test_drain_pause();
        test_random_lines(260);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> dda_line_rasterizer_unit.f
+incdir+hw/rtl
hw/rtl/dda_pkg.sv
hw/rtl/dda_ctrl.sv
hw/rtl/dda_dp.sv
hw/rtl/dda_line_rasterizer_unit.sv
test/dda_line_rasterizer_unit_tb.sv
